[src/gmis_pkg.sv]
// ----------------------------------------------------------------------------
// gmis_pkg
// Shared types and constants for the greedy minimum-degree independent set.
// ----------------------------------------------------------------------------
package gmis_pkg;

  localparam int VCOUNT_W = 7;
  localparam int IDX_W    = 6;
  localparam int DEG_W    = 7;

  localparam logic REQ_ADD_EDGE = 1'b0;
  localparam logic REQ_SOLVE    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEG,
    S_SCAN,
    S_REMOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [DEG_W-1:0]    deg;
    logic [IDX_W-1:0]    idx;
  } cand_t;

  typedef struct packed {
    logic                clear;
    logic                add_en;
    logic                start;
    logic                calc;
    logic                scan;
    logic                remove;
    logic [VCOUNT_W-1:0] vcount;
  } ctl_t;

endpackage

[src/gmis_cell.sv]
// ----------------------------------------------------------------------------
// gmis_cell
// One vertex: adjacency row, alive flag, degree and one stage of the
// minimum-degree candidate chain.
// ----------------------------------------------------------------------------
module gmis_cell #(
  parameter int ROW_W    = 64,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gmis_pkg::ctl_t     ctl,
  input  logic [ROW_W-1:0]   a_vec,
  input  logic [ROW_W-1:0]   b_vec,
  input  logic [ROW_W-1:0]   sel_vec,
  input  logic [ROW_W-1:0]   alive_vec,
  input  gmis_pkg::cand_t    cand_in,
  output gmis_pkg::cand_t    cand_out,
  output logic               alive
);

  logic [ROW_W-1:0]               row_r, row_nxt;
  logic                           alive_r, alive_nxt;
  logic [gmis_pkg::DEG_W-1:0]     deg_r, deg_nxt;
  gmis_pkg::cand_t                cand_r, cand_nxt;
  logic [ROW_W-1:0]               live_nbr;
  logic                           hit;

  assign live_nbr = row_r & alive_vec;
  assign hit      = (|(row_r & sel_vec)) | sel_vec[CELL_IDX];

  always_comb begin
    row_nxt = row_r;
    if (ctl.clear) begin
      row_nxt = '0;
    end else if (ctl.add_en) begin
      if (a_vec[CELL_IDX]) begin
        row_nxt = row_nxt | b_vec;
      end
      if (b_vec[CELL_IDX]) begin
        row_nxt = row_nxt | a_vec;
      end
    end
  end

  always_comb begin
    alive_nxt = alive_r;
    if (ctl.start) begin
      alive_nxt = (gmis_pkg::VCOUNT_W'(CELL_IDX) < ctl.vcount);
    end else if (ctl.remove && hit) begin
      alive_nxt = 1'b0;
    end
  end

  always_comb begin
    deg_nxt = deg_r;
    if (ctl.calc) begin
      deg_nxt = '0;
      for (int j = 0; j < ROW_W; j++) begin
        deg_nxt = deg_nxt + gmis_pkg::DEG_W'(live_nbr[j]);
      end
    end
  end

  always_comb begin
    cand_nxt = cand_r;
    if (ctl.calc) begin
      cand_nxt.valid = 1'b0;
    end else if (ctl.scan) begin
      if (alive_r && (!cand_in.valid || (deg_r < cand_in.deg))) begin
        cand_nxt.valid = 1'b1;
        cand_nxt.deg   = deg_r;
        cand_nxt.idx   = gmis_pkg::IDX_W'(CELL_IDX);
      end else begin
        cand_nxt = cand_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      alive_r      <= 1'b0;
      cand_r.valid <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      alive_r <= alive_nxt;
      cand_r  <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_r <= deg_nxt;
  end

  assign cand_out = cand_r;
  assign alive    = alive_r;

endmodule

[src/greedy_min_degree_independent_set.sv]
// ----------------------------------------------------------------------------
// greedy_min_degree_independent_set
// Greedy minimum-degree independent set over an adjacency bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_req_type selects add-edge or solve.
//   An add-edge transaction gives no result; while no solve runs, edges
//   stream at one per cycle. A self loop or an end at or beyond the vertex
//   count is dropped.
//   A solve transaction returns set_size on the output channel
//   (out_valid/out_ready). Each greedy round registers every cell's degree,
//   ripples the minimum-degree candidate down the cell chain, then removes
//   the winner and its neighbors. in_ready is low while a solve runs.
//   cfg_wr_en writes the vertex count (saturated to MAX_VERTICES) and clears
//   all edges in the same cycle; write only while idle.
//   Reset clears the matrix, sets the vertex count to 0 and drops any result.
//   The result sits in an output register; edges are still taken while it
//   waits, and a following solve holds its result until the register frees.
// ----------------------------------------------------------------------------
module greedy_min_degree_independent_set #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gmis_pkg::VCOUNT_W-1:0]     cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [gmis_pkg::IDX_W-1:0]        in_edge_from,
  input  logic [gmis_pkg::IDX_W-1:0]        in_edge_to,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gmis_pkg::VCOUNT_W-1:0]     out_set_size
);

  localparam int CNT_W = $clog2(MAX_VERTICES);

  gmis_pkg::state_t                 state_r, state_nxt;
  logic [gmis_pkg::VCOUNT_W-1:0]    vcount_r, vcount_nxt;
  logic [gmis_pkg::VCOUNT_W-1:0]    picked_r, picked_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [gmis_pkg::VCOUNT_W-1:0]    out_size_r, out_size_nxt;

  gmis_pkg::ctl_t                   ctl;
  logic [MAX_VERTICES-1:0]          a_vec, b_vec, sel_vec, alive_vec;
  gmis_pkg::cand_t                  cand_w [MAX_VERTICES+1];
  logic                             in_acc, edge_ok;

  assign in_acc  = in_valid && in_ready;
  assign edge_ok = (in_edge_from != in_edge_to) &&
                   ({1'b0, in_edge_from} < vcount_r) &&
                   ({1'b0, in_edge_to} < vcount_r);

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      a_vec[j]   = (in_edge_from == gmis_pkg::IDX_W'(j));
      b_vec[j]   = (in_edge_to == gmis_pkg::IDX_W'(j));
      sel_vec[j] = (cand_w[MAX_VERTICES].idx == gmis_pkg::IDX_W'(j));
    end
  end

  assign cand_w[0] = '0;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    gmis_cell #(
      .ROW_W    (MAX_VERTICES),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .a_vec     (a_vec),
      .b_vec     (b_vec),
      .sel_vec   (sel_vec),
      .alive_vec (alive_vec),
      .cand_in   (cand_w[i]),
      .cand_out  (cand_w[i+1]),
      .alive     (alive_vec[i])
    );
  end

  always_comb begin
    vcount_nxt = vcount_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data > gmis_pkg::VCOUNT_W'(MAX_VERTICES)) begin
        vcount_nxt = gmis_pkg::VCOUNT_W'(MAX_VERTICES);
      end else begin
        vcount_nxt = cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    picked_nxt    = picked_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_size_nxt  = out_size_r;
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.clear     = cfg_wr_en;
    ctl.vcount    = vcount_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      gmis_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (in_req_type == gmis_pkg::REQ_SOLVE) begin
            ctl.start  = 1'b1;
            picked_nxt = '0;
            state_nxt  = gmis_pkg::S_DEG;
          end else begin
            ctl.add_en = edge_ok;
          end
        end
      end
      gmis_pkg::S_DEG: begin
        if (alive_vec == '0) begin
          state_nxt = gmis_pkg::S_DONE;
        end else begin
          ctl.calc  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = gmis_pkg::S_SCAN;
        end
      end
      gmis_pkg::S_SCAN: begin
        ctl.scan = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAX_VERTICES - 1)) begin
          state_nxt = gmis_pkg::S_REMOVE;
        end
      end
      gmis_pkg::S_REMOVE: begin
        ctl.remove = 1'b1;
        picked_nxt = picked_r + 1'b1;
        state_nxt  = gmis_pkg::S_DEG;
      end
      gmis_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_size_nxt  = picked_r;
          state_nxt     = gmis_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gmis_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmis_pkg::S_IDLE;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    picked_r   <= picked_nxt;
    cnt_r      <= cnt_nxt;
    out_size_r <= out_size_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_set_size = out_size_r;

endmodule

[src/gmis_checker.sv]
// ----------------------------------------------------------------------------
// gmis_checker
// Port-level checks for the greedy minimum-degree independent set block.
// ----------------------------------------------------------------------------
module gmis_checker #(
  parameter int MAX_VERTICES = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_req_type,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gmis_pkg::VCOUNT_W-1:0]     out_set_size
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_set_size))
    else $error("result changed while stalled");

  // a solve transaction makes the block busy
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == gmis_pkg::REQ_SOLVE) |=> !in_ready)
    else $error("input taken right after a solve");

  // an edge transaction produces no result
  a_edge_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == gmis_pkg::REQ_ADD_EDGE) && !out_valid
    |=> !out_valid)
    else $error("result after an edge transaction");

  // set size never exceeds the vertex limit
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_set_size <= gmis_pkg::VCOUNT_W'(MAX_VERTICES))
    else $error("set size out of range");

endmodule

bind greedy_min_degree_independent_set gmis_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_gmis_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_req_type  (in_req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_set_size (out_set_size)
);

[verif/greedy_min_degree_independent_set_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_min_degree_independent_set_tb
// Self-checking bench for the greedy minimum-degree independent set block.
// Edge and solve transactions are queued by the stimulus process. A clocked
// driver and monitor move them over the valid/ready channels. Every accepted
// in-range edge updates a local copy of the adjacency matrix, and every solve
// queues the expected set size. Each phase writes a new vertex count while
// the block is idle, then streams edges and solves under one idling pattern.
// ----------------------------------------------------------------------------
module greedy_min_degree_independent_set_tb;

  localparam int          NV          = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                       req_type;
    logic [gmis_pkg::IDX_W-1:0] edge_from;
    logic [gmis_pkg::IDX_W-1:0] edge_to;
  } gmis_req_t;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          cfg_wr_en    = 1'b0;
  logic [gmis_pkg::VCOUNT_W-1:0] cfg_wr_data  = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic                          in_req_type  = gmis_pkg::REQ_ADD_EDGE;
  logic [gmis_pkg::IDX_W-1:0]    in_edge_from = '0;
  logic [gmis_pkg::IDX_W-1:0]    in_edge_to   = '0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic [gmis_pkg::VCOUNT_W-1:0] out_set_size;

  // local graph copy
  logic [NV-1:0]       adj_rows [NV];
  int unsigned         vc_model;

  gmis_req_t                     req_q [$];
  logic [gmis_pkg::VCOUNT_W-1:0] set_size_q [$];

  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int          err_count       = 0;
  int          req_count       = 0;
  int          solve_count     = 0;
  int          result_count    = 0;
  int          cfg_count       = 0;
  int unsigned cycle_count     = 0;

  greedy_min_degree_independent_set #(
    .MAX_VERTICES(NV)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_edge_from (in_edge_from),
    .in_edge_to   (in_edge_to),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_set_size (out_set_size)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [gmis_pkg::VCOUNT_W-1:0] greedy_set_size();
    logic [NV-1:0] alive;
    int            picked;
    int            best;
    int            best_deg;
    int            d;
    alive  = (vc_model >= NV) ? '1 : ((64'd1 << vc_model) - 64'd1);
    picked = 0;
    while (alive != '0) begin
      best     = 0;
      best_deg = NV + 1;
      for (int v = 0; v < vc_model; v++) begin
        if (alive[v]) begin
          d = $countones(adj_rows[v] & alive);
          if (d < best_deg) begin
            best_deg = d;
            best     = v;
          end
        end
      end
      alive[best] = 1'b0;
      alive       = alive & ~adj_rows[best];
      picked++;
    end
    return picked[gmis_pkg::VCOUNT_W-1:0];
  endfunction

  function automatic void absorb_request(input logic rt,
                                         input logic [gmis_pkg::IDX_W-1:0] a,
                                         input logic [gmis_pkg::IDX_W-1:0] b);
    if (rt == gmis_pkg::REQ_SOLVE) begin
      set_size_q.push_back(greedy_set_size());
      solve_count++;
    end else if (a != b && a < vc_model && b < vc_model) begin
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
    end
    req_count++;
  endfunction

  // driver
  always @(posedge clk) begin : driver
    gmis_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        absorb_request(in_req_type, in_edge_from, in_edge_to);
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt          = req_q.pop_front();
          in_valid     <= 1'b1;
          in_req_type  <= nxt.req_type;
          in_edge_from <= nxt.edge_from;
          in_edge_to   <= nxt.edge_to;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    logic [gmis_pkg::VCOUNT_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (set_size_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result set_size=%0d", out_set_size));
        end else begin
          want = set_size_q.pop_front();
          if (out_set_size !== want)
            report_mismatch($sformatf("set_size got %0d want %0d", out_set_size, want));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               set_size_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_req(input logic rt, input logic [gmis_pkg::IDX_W-1:0] a,
                          input logic [gmis_pkg::IDX_W-1:0] b);
    gmis_req_t r;
    r.req_type  = rt;
    r.edge_from = a;
    r.edge_to   = b;
    req_q.push_back(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || set_size_q.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [gmis_pkg::VCOUNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vc_model = (value > NV) ? NV : value;
    for (int i = 0; i < NV; i++)
      adj_rows[i] = '0;
    cfg_count++;
    @(negedge clk);
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  // mostly in-range edges with some noise; solves sprinkled in
  task automatic gen_phase(input int budget, input int max_items);
    int                         useful;
    int                         items;
    int                         solve_pct;
    logic [gmis_pkg::IDX_W-1:0] a;
    logic [gmis_pkg::IDX_W-1:0] b;
    useful    = 0;
    items     = 0;
    solve_pct = (vc_model >= 48) ? 3 : 9;
    while (useful < budget && items < max_items) begin
      items++;
      if ($urandom_range(0, 99) < solve_pct) begin
        push_req(gmis_pkg::REQ_SOLVE, gmis_pkg::IDX_W'($urandom_range(0, NV - 1)),
                 gmis_pkg::IDX_W'($urandom_range(0, NV - 1)));
        useful++;
      end else if (vc_model >= 2 && $urandom_range(0, 99) < 85) begin
        a = gmis_pkg::IDX_W'($urandom_range(0, vc_model - 1));
        b = gmis_pkg::IDX_W'($urandom_range(0, vc_model - 1));
        if (a == b)
          b = gmis_pkg::IDX_W'((a + 1) % vc_model);
        push_req(gmis_pkg::REQ_ADD_EDGE, a, b);
        useful++;
      end else begin
        a = gmis_pkg::IDX_W'($urandom_range(0, NV - 1));
        b = gmis_pkg::IDX_W'($urandom_range(0, NV - 1));
        push_req(gmis_pkg::REQ_ADD_EDGE, a, b);
        if (a != b && a < vc_model && b < vc_model)
          useful++;
      end
    end
  endtask

  int phase_vc [16] = '{9, 64, 5, 127, 0, -1, 1, 2, 33, 64, 7, 100, 16, 3, -1, 64};

  initial begin
    for (int i = 0; i < NV; i++)
      adj_rows[i] = '0;
    vc_model = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty graph straight out of reset
    set_idle_mode(0);
    push_req(gmis_pkg::REQ_SOLVE, 6'd63, 6'd0);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd1);
    push_req(gmis_pkg::REQ_SOLVE, 6'd0, 6'd63);
    wait_idle();

    // oversized count saturates; duplicates, self loops
    write_vertex_count(7'd127);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd63);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd63, 6'd0);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd5, 6'd5);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd62, 6'd63);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd63, 6'd63);
    push_req(gmis_pkg::REQ_SOLVE, 6'h2A, 6'h15);
    wait_idle();

    write_vertex_count(7'd0);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd1, 6'd0);
    push_req(gmis_pkg::REQ_SOLVE, 6'd0, 6'd0);
    wait_idle();

    write_vertex_count(7'd1);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd0);
    push_req(gmis_pkg::REQ_SOLVE, 6'd0, 6'd0);
    wait_idle();

    write_vertex_count(7'd2);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd1);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd1, 6'd2);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd2, 6'd1);
    push_req(gmis_pkg::REQ_SOLVE, 6'd21, 6'd42);
    wait_idle();

    write_vertex_count(7'd65);
    push_req(gmis_pkg::REQ_SOLVE, 6'd63, 6'd63);
    wait_idle();

    // star, then complete graph on four vertices
    write_vertex_count(7'd4);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd1);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd2);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd0, 6'd3);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd3, 6'd4);
    push_req(gmis_pkg::REQ_SOLVE, 6'd0, 6'd0);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd1, 6'd2);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd2, 6'd3);
    push_req(gmis_pkg::REQ_ADD_EDGE, 6'd1, 6'd3);
    push_req(gmis_pkg::REQ_SOLVE, 6'd0, 6'd0);
    wait_idle();

    for (int p = 0; p < 16; p++) begin
      set_idle_mode(p);
      if (phase_vc[p] < 0)
        write_vertex_count(gmis_pkg::VCOUNT_W'($urandom_range(2, 24)));
      else
        write_vertex_count(gmis_pkg::VCOUNT_W'(phase_vc[p]));
      gen_phase(90, 120);
      push_req(gmis_pkg::REQ_SOLVE, gmis_pkg::IDX_W'($urandom_range(0, NV - 1)),
               gmis_pkg::IDX_W'($urandom_range(0, NV - 1)));
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (set_size_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", set_size_q.size()));

    $display("Ran %0d request transactions (%0d solves) across %0d vertex-count writes",
             req_count, solve_count, cfg_count);
    $display("Checked %0d results, %0d mismatches", result_count, err_count);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
